/* hw/rtl/tta_pkg.sv */
// ----------------------------------------------------------------------------
// tta_pkg
// Shared types, register indexes, status codes and reset values of the
// tensor transpose address generator.
// ----------------------------------------------------------------------------
package tta_pkg;

	// fixed field widths
	localparam int AXIS_COUNT_W = 3;
	localparam int PERM_W       = 21;
	localparam int PERM_FIELD_W = 3;
	localparam int PERM_FIELDS  = 8;
	localparam int SHAPE_LOW_W  = 64;
	localparam int SHAPE_HIGH_W = 48;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_INDEX_W  = 2;
	localparam int OUT_INDEX_W  = 32;
	localparam int STATUS_W     = 2;
	localparam int AXIS_IDX_W   = 3;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_AXIS_COUNT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PERMUTATION = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_LOW   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_HIGH  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_ELEMENT    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_CONFIG = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FINISHED   = 2'd2;

	// register reset values: one axis, identity permutation, all sizes one
	localparam logic [AXIS_COUNT_W-1:0] RST_AXIS_COUNT = 3'd1;
	localparam logic [PERM_W-1:0]       RST_PERM       = 21'd1754760;
	localparam logic [SHAPE_LOW_W-1:0]  RST_SHAPE_LOW  = 64'd281479271743489;
	localparam logic [SHAPE_HIGH_W-1:0] RST_SHAPE_HIGH = 48'd4295032833;

	typedef struct packed {
		logic [AXIS_COUNT_W-1:0] axis_count;
		logic [PERM_W-1:0]       perm;
		logic [SHAPE_LOW_W-1:0]  shape_low;
		logic [SHAPE_HIGH_W-1:0] shape_high;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic                  restart;
		logic                  prep_step;
		logic                  recomp_start;
		logic                  recomp_step;
		logic                  step;
		logic [AXIS_IDX_W-1:0] idx;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic                    err;
		logic                    walk_active;
		logic                    dirty;
		logic [AXIS_COUNT_W-1:0] n_used;
	} dp_status_t;

endpackage

/* hw/rtl/tta_if.sv */
// ----------------------------------------------------------------------------
// tta channel interfaces
// Request channel (restart flag) and response channel (indices and status).
// ----------------------------------------------------------------------------
interface tta_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface tta_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [tta_pkg::OUT_INDEX_W-1:0] source_index;
	logic [tta_pkg::OUT_INDEX_W-1:0] dest_index;
	logic                             last_element;
	logic [tta_pkg::STATUS_W-1:0]    status;

	modport source (output valid, output source_index, output dest_index,
		output last_element, output status, input ready);
	modport sink (input valid, input source_index, input dest_index,
		input last_element, input status, output ready);
endinterface

/* hw/rtl/tensor_transpose_address_generator_core.sv */
// ----------------------------------------------------------------------------
// tensor_transpose_address_generator_core
// N-dimensional transpose address generator: emits source and destination
// linear indices, walking the output in row-major order.
// ----------------------------------------------------------------------------
// channel   dir   handshake     word contents
// request   in    valid/ready   restart
// response  out   valid/ready   source_index, dest_index, last_element, status
// cfg       in    cfg_write     cfg_index, cfg_data (no read-back)
//
// Plain steps run at one word per cycle; a response word that waits holds off
// the next request until the cycle in which it is taken.
// A restart runs n multiplies for n axes for the overflow check and strides,
// then n multiplies to load the lane registers, before its response word.
// The first step after a configuration write mid-walk first reloads the
// lanes with n multiplies. A bad configuration cuts the restart multiplies short.
// Reset loads the default registers and leaves the walk finished (status 2).
// ----------------------------------------------------------------------------
module tensor_transpose_address_generator_core #(
	parameter int MAX_AXES   = 7,
	parameter int DIM_BITS   = 16,
	parameter int INDEX_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [tta_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tta_pkg::CFG_DATA_W-1:0]   cfg_data,
	tta_req_if.sink                           request,
	tta_rsp_if.source                         response
);

	tta_pkg::cfg_t       cfg;
	tta_pkg::ctl_cmd_t   cmd;
	tta_pkg::dp_status_t dp_status;
	logic                req_ready;
	logic                rsp_valid;

	// configuration registers
	tta_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer and handshake
	tta_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (request.valid),
		.req_restart (request.restart),
		.req_ready   (req_ready),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (response.ready),
		.status      (dp_status),
		.cmd         (cmd)
	);

	// strides, odometer and response word
	tta_datapath #(
		.MAX_AXES   (MAX_AXES),
		.DIM_BITS   (DIM_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cfg_write    (cfg_write),
		.cmd          (cmd),
		.status       (dp_status),
		.source_index (response.source_index),
		.dest_index   (response.dest_index),
		.last_element (response.last_element),
		.status_code  (response.status)
	);

	assign request.ready  = req_ready;
	assign response.valid = rsp_valid;

endmodule

/* hw/rtl/tta_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tta_cfg_regs
// Configuration register file: axis count, permutation and input shape.
// ----------------------------------------------------------------------------
module tta_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [tta_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tta_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tta_pkg::cfg_t                     cfg
);

	tta_pkg::cfg_t cfg_q;

	// register writes, truncated to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_count <= tta_pkg::RST_AXIS_COUNT;
			cfg_q.perm       <= tta_pkg::RST_PERM;
			cfg_q.shape_low  <= tta_pkg::RST_SHAPE_LOW;
			cfg_q.shape_high <= tta_pkg::RST_SHAPE_HIGH;
		end else if (cfg_write) begin
			case (cfg_index)
				tta_pkg::REG_AXIS_COUNT: begin
					cfg_q.axis_count <= cfg_data[tta_pkg::AXIS_COUNT_W-1:0];
				end
				tta_pkg::REG_PERMUTATION: begin
					cfg_q.perm <= cfg_data[tta_pkg::PERM_W-1:0];
				end
				tta_pkg::REG_SHAPE_LOW: begin
					cfg_q.shape_low <= cfg_data[tta_pkg::SHAPE_LOW_W-1:0];
				end
				tta_pkg::REG_SHAPE_HIGH: begin
					cfg_q.shape_high <= cfg_data[tta_pkg::SHAPE_HIGH_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/tta_datapath.sv */
// ----------------------------------------------------------------------------
// tta_datapath
// Strides, per-axis odometer, suffix offset sums and the response register.
// ----------------------------------------------------------------------------
module tta_datapath #(
	parameter int MAX_AXES   = 7,
	parameter int DIM_BITS   = 16,
	parameter int INDEX_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tta_pkg::cfg_t                     cfg,
	input  logic                              cfg_write,
	input  tta_pkg::ctl_cmd_t                 cmd,
	output tta_pkg::dp_status_t               status,
	output logic [tta_pkg::OUT_INDEX_W-1:0]  source_index,
	output logic [tta_pkg::OUT_INDEX_W-1:0]  dest_index,
	output logic                              last_element,
	output logic [tta_pkg::STATUS_W-1:0]     status_code
);

	localparam int AW = $clog2(MAX_AXES);
	localparam int PW = INDEX_BITS + DIM_BITS + 1;
	localparam logic [PW-1:0] PROD_LIMIT = PW'(1) << INDEX_BITS;

	// configuration views
	logic [DIM_BITS-1:0]                dims [MAX_AXES];
	logic [tta_pkg::PERM_FIELD_W-1:0]   pf [tta_pkg::PERM_FIELDS];
	logic [127:0]                       low_ext;
	logic [127:0]                       high_ext;
	logic [tta_pkg::PERM_FIELDS*tta_pkg::PERM_FIELD_W-1:0] perm_ext;
	logic [tta_pkg::AXIS_COUNT_W-1:0]   n_used;

	// walk state
	logic [DIM_BITS-1:0]   counter_q  [MAX_AXES];
	logic [INDEX_BITS-1:0] stride_q   [MAX_AXES];
	logic [DIM_BITS-1:0]   lane_lim_q [MAX_AXES];
	logic [INDEX_BITS-1:0] lane_st_q  [MAX_AXES];
	logic [INDEX_BITS-1:0] sfx_q      [MAX_AXES];
	logic [INDEX_BITS-1:0] sfx_next   [MAX_AXES];
	logic [INDEX_BITS-1:0] src_q;
	logic [INDEX_BITS-1:0] dest_q;
	logic [INDEX_BITS:0]   total_q;
	logic [INDEX_BITS-1:0] acc_q;
	logic                  err_q;
	logic                  walk_q;
	logic                  dirty_q;

	// response register
	logic [tta_pkg::OUT_INDEX_W-1:0] src_out_q;
	logic [tta_pkg::OUT_INDEX_W-1:0] dest_out_q;
	logic                            last_out_q;
	logic [tta_pkg::STATUS_W-1:0]    status_out_q;

	// restart checks
	logic bad_n;
	logic bad_perm;

	// shared unit for prep and recompute
	logic [AW-1:0]                    k;
	logic [AW-1:0]                    km1;
	logic [tta_pkg::PERM_FIELD_W-1:0] rp;
	logic                             rp_ok;
	logic [AW-1:0]                    rpa;
	logic [AW-1:0]                    dsel_idx;
	logic [DIM_BITS-1:0]              dsel;
	logic [PW-1:0]                    prod;
	logic                             prep_bad;
	logic [DIM_BITS-1:0]              rl;
	logic [INDEX_BITS-1:0]            rs;
	logic [DIM_BITS+INDEX_BITS-1:0]   rmul;
	logic [INDEX_BITS-1:0]            rsum;

	// odometer step
	logic [MAX_AXES-1:0]   used;
	logic [MAX_AXES-1:0]   can;
	logic                  found;
	logic [AW-1:0]         kf;
	logic [INDEX_BITS-1:0] delta;
	logic                  walk_ok;

	assign low_ext  = {64'b0, cfg.shape_low};
	assign high_ext = {80'b0, cfg.shape_high};
	assign perm_ext = {3'b0, cfg.perm};

	// input sizes per axis, zero beyond the register bits
	for (genvar a = 0; a < MAX_AXES; a++) begin : g_dims
		if (a < 4) begin : g_low
			if (a * DIM_BITS < 64) begin : g_in
				assign dims[a] = low_ext[a*DIM_BITS +: DIM_BITS];
			end else begin : g_out
				assign dims[a] = '0;
			end
		end else begin : g_high
			if ((a - 4) * DIM_BITS < 64) begin : g_in
				assign dims[a] = high_ext[(a-4)*DIM_BITS +: DIM_BITS];
			end else begin : g_out
				assign dims[a] = '0;
			end
		end
	end

	for (genvar i = 0; i < tta_pkg::PERM_FIELDS; i++) begin : g_perm
		assign pf[i] = perm_ext[i*tta_pkg::PERM_FIELD_W +: tta_pkg::PERM_FIELD_W];
	end

	assign n_used = ({1'b0, cfg.axis_count} > 4'(MAX_AXES)) ?
		tta_pkg::AXIS_COUNT_W'(MAX_AXES) : cfg.axis_count;

	// axis count and permutation checks at restart
	assign bad_n = (cfg.axis_count == '0) || ({1'b0, cfg.axis_count} > 4'(MAX_AXES));

	always_comb begin
		bad_perm = 1'b0;
		for (int i = 0; i < tta_pkg::PERM_FIELDS; i++) begin
			if (3'(i) < cfg.axis_count) begin
				if (pf[i] >= cfg.axis_count) begin
					bad_perm = 1'b1;
				end
				for (int j = 0; j < i; j++) begin
					if (pf[j] == pf[i]) begin
						bad_perm = 1'b1;
					end
				end
			end
		end
	end

	// one multiply per cycle: total/stride during prep, lane offset in recompute
	assign k        = cmd.idx[AW-1:0];
	assign km1      = k - 1'b1;
	assign rp       = pf[cmd.idx];
	assign rp_ok    = {1'b0, rp} < 4'(MAX_AXES);
	assign rpa      = rp[AW-1:0];
	assign dsel_idx = cmd.recomp_step ? rpa : k;
	assign dsel     = dims[dsel_idx];
	assign prod     = total_q * dsel;
	assign prep_bad = (dsel == '0) || (prod > PROD_LIMIT);
	assign rl       = rp_ok ? dsel : DIM_BITS'(1);
	assign rs       = rp_ok ? stride_q[rpa] : '0;
	assign rmul     = counter_q[k] * rs;
	assign rsum     = rmul[INDEX_BITS-1:0] + acc_q;

	// odometer carry search over the used output axes
	for (genvar a = 0; a < MAX_AXES; a++) begin : g_lane
		logic [DIM_BITS:0] cnt_inc;
		assign used[a]  = 3'(a) < n_used;
		assign cnt_inc  = {1'b0, counter_q[a]} + 1'b1;
		assign can[a]   = used[a] && (cnt_inc < {1'b0, lane_lim_q[a]});
		if (a + 1 < MAX_AXES) begin : g_sfx
			assign sfx_next[a] = sfx_q[a+1];
		end else begin : g_sfx_end
			assign sfx_next[a] = '0;
		end
	end

	always_comb begin
		found = 1'b0;
		kf    = '0;
		for (int a = 0; a < MAX_AXES; a++) begin
			if (can[a]) begin
				found = 1'b1;
				kf    = AW'(a);
			end
		end
	end

	assign delta   = found ? (lane_st_q[kf] - sfx_next[kf]) : ('0 - sfx_q[0]);
	assign walk_ok = !err_q && walk_q;

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q   <= 1'b0;
			walk_q  <= 1'b0;
			dirty_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				err_q  <= bad_n || bad_perm;
				walk_q <= 1'b1;
			end
			if (cmd.prep_step && prep_bad) begin
				err_q <= 1'b1;
			end
			if (cfg_write) begin
				dirty_q <= 1'b1;
			end else if (cmd.recomp_start) begin
				dirty_q <= 1'b0;
			end
			if (cmd.step && walk_ok && !found) begin
				walk_q <= 1'b0;
			end
		end
	end

	// walk state updates
	always_ff @(posedge clk) begin
		if (cmd.restart) begin
			for (int a = 0; a < MAX_AXES; a++) begin
				counter_q[a] <= '0;
				sfx_q[a]     <= '0;
				stride_q[a]  <= (3'(a) == cfg.axis_count - 3'd1) ? INDEX_BITS'(1) : '0;
			end
			src_q   <= '0;
			dest_q  <= '0;
			total_q <= (INDEX_BITS+1)'(1);
		end
		if (cmd.prep_step) begin
			if (!prep_bad) begin
				total_q <= prod[INDEX_BITS:0];
			end
			if (k != '0) begin
				stride_q[km1] <= prod[INDEX_BITS-1:0];
			end
		end
		if (cmd.recomp_start) begin
			for (int a = 0; a < MAX_AXES; a++) begin
				sfx_q[a] <= '0;
			end
			acc_q <= '0;
		end
		if (cmd.recomp_step) begin
			lane_lim_q[k] <= rl;
			lane_st_q[k]  <= rs;
			sfx_q[k]      <= rsum;
			acc_q         <= rsum;
		end
		if (cmd.step && walk_ok) begin
			dest_q <= dest_q + 1'b1;
			src_q  <= src_q + delta;
			for (int a = 0; a < MAX_AXES; a++) begin
				if (found && AW'(a) <= kf) begin
					sfx_q[a] <= sfx_q[a] + delta;
				end else begin
					sfx_q[a] <= '0;
				end
				if (found && AW'(a) == kf) begin
					counter_q[a] <= counter_q[a] + 1'b1;
				end else if (used[a] && (!found || AW'(a) > kf)) begin
					counter_q[a] <= '0;
				end
			end
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (err_q) begin
				src_out_q    <= '0;
				dest_out_q   <= '0;
				last_out_q   <= 1'b0;
				status_out_q <= tta_pkg::STATUS_BAD_CONFIG;
			end else if (!walk_q) begin
				src_out_q    <= '0;
				dest_out_q   <= '0;
				last_out_q   <= 1'b0;
				status_out_q <= tta_pkg::STATUS_FINISHED;
			end else begin
				src_out_q    <= tta_pkg::OUT_INDEX_W'(src_q);
				dest_out_q   <= tta_pkg::OUT_INDEX_W'(dest_q);
				last_out_q   <= !found;
				status_out_q <= tta_pkg::STATUS_ELEMENT;
			end
		end
	end

	assign source_index = src_out_q;
	assign dest_index   = dest_out_q;
	assign last_element = last_out_q;
	assign status_code  = status_out_q;

	assign status.err         = err_q;
	assign status.walk_active = walk_q;
	assign status.dirty       = dirty_q;
	assign status.n_used      = n_used;

endmodule

/* hw/rtl/tta_ctrl.sv */
// ----------------------------------------------------------------------------
// tta_ctrl
// Sequencer for restart prep, lane recompute and element steps, plus the
// request/response handshake.
// ----------------------------------------------------------------------------
module tta_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_restart,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  tta_pkg::dp_status_t  status,
	output tta_pkg::ctl_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_PREP   = 2'd1;
	localparam logic [1:0] ST_RECOMP = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0]                     state_q;
	logic [1:0]                     state_d;
	logic [tta_pkg::AXIS_IDX_W-1:0] idx_q;
	logic [tta_pkg::AXIS_IDX_W-1:0] idx_d;
	logic [tta_pkg::AXIS_IDX_W-1:0] last_axis;
	logic                           out_valid_q;
	logic                           accept;

	assign req_ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_ready);
	assign rsp_valid = out_valid_q;
	assign accept    = req_valid && req_ready;
	assign last_axis = status.n_used - 3'd1;

	// next state and datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		idx_d   = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_restart) begin
						cmd.restart = 1'b1;
						idx_d       = last_axis;
						state_d     = ST_PREP;
					end else if (status.walk_active && !status.err && status.dirty) begin
						cmd.recomp_start = 1'b1;
						idx_d            = last_axis;
						state_d          = (status.n_used == '0) ? ST_EMIT : ST_RECOMP;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			ST_PREP: begin
				if (status.err) begin
					state_d = ST_EMIT;
				end else begin
					cmd.prep_step = 1'b1;
					cmd.idx       = idx_q;
					if (idx_q == '0) begin
						cmd.recomp_start = 1'b1;
						idx_d            = last_axis;
						state_d          = ST_RECOMP;
					end else begin
						idx_d = idx_q - 1'b1;
					end
				end
			end
			ST_RECOMP: begin
				cmd.recomp_step = 1'b1;
				cmd.idx         = idx_q;
				if (idx_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					idx_d = idx_q - 1'b1;
				end
			end
			ST_EMIT: begin
				cmd.step = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, axis index and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* tb/tb_tensor_transpose_address_generator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tensor_transpose_address_generator_core
// Drives restart/advance words into the transpose address generator and checks
// every response word against an in-bench odometer predictor. Directed cases
// cover reset state, small transposes, index range limits, bad configurations
// and rewrites during a walk. Random walks follow over four idling phases.
// ----------------------------------------------------------------------------
module tb_tensor_transpose_address_generator_core;

	localparam int AXES = 7;
	localparam longint unsigned INDEX_SPAN = 64'h1_0000_0000;

	typedef struct packed {
		logic [tta_pkg::OUT_INDEX_W-1:0] source_index;
		logic [tta_pkg::OUT_INDEX_W-1:0] dest_index;
		logic                            last_element;
		logic [tta_pkg::STATUS_W-1:0]    status;
	} addr_word_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_write;
	logic [tta_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [tta_pkg::CFG_DATA_W-1:0]  cfg_data;

	tta_req_if req_ch ();
	tta_rsp_if rsp_ch ();

	tensor_transpose_address_generator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (req_ch),
		.response  (rsp_ch)
	);

	// register copies seen by the predictor
	logic [tta_pkg::AXIS_COUNT_W-1:0] m_axis_count;
	logic [tta_pkg::PERM_W-1:0]       m_perm;
	logic [tta_pkg::SHAPE_LOW_W-1:0]  m_shape_low;
	logic [tta_pkg::SHAPE_HIGH_W-1:0] m_shape_high;

	// walk state of the predictor
	logic [15:0]                     odo [8];
	logic [tta_pkg::OUT_INDEX_W-1:0] stride [8];
	logic [tta_pkg::OUT_INDEX_W-1:0] src_acc;
	logic [tta_pkg::OUT_INDEX_W-1:0] dst_acc;
	bit                              walking;
	bit                              bad_cfg;

	addr_word_t  pending_addr_q [$];
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned items_sent     = 0;
	int unsigned words_checked  = 0;
	int unsigned mismatch_count = 0;
	int unsigned walks_done     = 0;
	int unsigned bad_cfg_cases  = 0;
	int unsigned rewrites_done  = 0;

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int perm_at(input int i);
		return (i < AXES) ? int'(m_perm[3*i +: 3]) : 7;
	endfunction

	function automatic logic [15:0] dim_at(input int a);
		if (a < 4)
			return m_shape_low[16*a +: 16];
		else if (a < AXES)
			return m_shape_high[16*(a-4) +: 16];
		return 16'd0;
	endfunction

	// restart check: permutation, sizes, element total; then row-major strides
	function automatic bit prepare_strides();
		int n, i, p;
		bit seen [8];
		longint unsigned total, d;
		n = int'(m_axis_count);
		if (n == 0 || n > AXES)
			return 1'b0;
		for (i = 0; i < 8; i++)
			seen[i] = 1'b0;
		for (i = 0; i < n; i++) begin
			p = perm_at(i);
			if (p >= n || seen[p])
				return 1'b0;
			seen[p] = 1'b1;
		end
		total = 1;
		for (i = 0; i < n; i++) begin
			d = 64'(dim_at(i));
			if (d == 0 || total > INDEX_SPAN / d)
				return 1'b0;
			total *= d;
		end
		for (i = 0; i < 8; i++)
			stride[i] = '0;
		stride[n-1] = 1;
		for (i = n - 1; i >= 1; i--)
			stride[i-1] = dim_at(i) * stride[i];
		return 1'b1;
	endfunction

	// odometer over output axes, last axis fastest; 1 when every axis wrapped
	function automatic bit step_odometer();
		int n, i, k, p;
		longint unsigned lim;
		logic [tta_pkg::OUT_INDEX_W-1:0] st;
		n = int'(m_axis_count);
		if (n > AXES)
			n = AXES;
		dst_acc = dst_acc + 1;
		for (k = n; k > 0; k--) begin
			i = k - 1;
			p = perm_at(i);
			lim = 1;
			st = '0;
			// a field naming no real axis behaves as a size-one axis
			if (p < AXES) begin
				lim = 64'(dim_at(p));
				st = stride[p];
			end
			if (odo[i] + 64'd1 < lim) begin
				odo[i] = odo[i] + 16'd1;
				src_acc = src_acc + st;
				return 1'b0;
			end
			src_acc = src_acc - odo[i] * st;
			odo[i] = '0;
		end
		return 1'b1;
	endfunction

	function automatic addr_word_t next_address_word(input logic restart_bit);
		addr_word_t w;
		int i;
		w = '{'0, '0, 1'b0, tta_pkg::STATUS_ELEMENT};
		if (restart_bit) begin
			for (i = 0; i < 8; i++)
				odo[i] = '0;
			src_acc = '0;
			dst_acc = '0;
			bad_cfg = !prepare_strides();
			walking = !bad_cfg;
		end
		if (bad_cfg)
			w.status = tta_pkg::STATUS_BAD_CONFIG;
		else if (!walking)
			w.status = tta_pkg::STATUS_FINISHED;
		else begin
			w.source_index = src_acc;
			w.dest_index = dst_acc;
			w.last_element = step_odometer();
			if (w.last_element)
				walking = 1'b0;
		end
		return w;
	endfunction

	// response check first, then predict for the request word taken this edge
	always @(posedge clk) begin : score_b
		addr_word_t got, want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.source_index, rsp_ch.dest_index,
				rsp_ch.last_element, rsp_ch.status};
			if (pending_addr_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected word: src %h dst %h last %b status %0d",
					$time, got.source_index, got.dest_index, got.last_element, got.status);
			end else begin
				want = pending_addr_q.pop_front();
				words_checked++;
				if (got !== want) begin
					mismatch_count++;
					$display("%0t: mismatch: expected %h/%h/%b/%0d got %h/%h/%b/%0d", $time,
						want.source_index, want.dest_index, want.last_element, want.status,
						got.source_index, got.dest_index, got.last_element, got.status);
				end
			end
		end
		if (req_ch.valid && req_ch.ready) begin
			want = next_address_word(req_ch.restart);
			pending_addr_q.insert(pending_addr_q.size(), want);
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		rsp_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// one request word, with random idle cycles ahead of it
	task automatic send_request(input logic restart_bit);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.restart <= restart_bit;
		do
			@(posedge clk);
		while (!req_ch.ready);
		items_sent++;
	endtask

	// stop sending and wait for every expected word
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_addr_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tta_pkg::CFG_INDEX_W-1:0] idx,
		input logic [tta_pkg::CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			tta_pkg::REG_AXIS_COUNT:  m_axis_count = data[tta_pkg::AXIS_COUNT_W-1:0];
			tta_pkg::REG_PERMUTATION: m_perm = data[tta_pkg::PERM_W-1:0];
			tta_pkg::REG_SHAPE_LOW:   m_shape_low = data[tta_pkg::SHAPE_LOW_W-1:0];
			tta_pkg::REG_SHAPE_HIGH:  m_shape_high = data[tta_pkg::SHAPE_HIGH_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic write_one(input logic [tta_pkg::CFG_INDEX_W-1:0] idx,
		input logic [tta_pkg::CFG_DATA_W-1:0] data);
		write_reg(idx, data);
		cfg_write <= 1'b0;
	endtask

	task automatic configure(input logic [tta_pkg::AXIS_COUNT_W-1:0] n,
		input logic [tta_pkg::PERM_W-1:0] perm,
		input logic [tta_pkg::SHAPE_LOW_W-1:0] lo,
		input logic [tta_pkg::SHAPE_HIGH_W-1:0] hi);
		write_reg(tta_pkg::REG_AXIS_COUNT, tta_pkg::CFG_DATA_W'(n));
		write_reg(tta_pkg::REG_PERMUTATION, tta_pkg::CFG_DATA_W'(perm));
		write_reg(tta_pkg::REG_SHAPE_LOW, lo);
		write_reg(tta_pkg::REG_SHAPE_HIGH, tta_pkg::CFG_DATA_W'(hi));
		cfg_write <= 1'b0;
	endtask

	// random valid shape, shuffled permutation, element total kept at or under cap
	task automatic pick_walk_shape(input int cap,
		output logic [tta_pkg::AXIS_COUNT_W-1:0] n,
		output logic [tta_pkg::PERM_W-1:0] perm,
		output logic [tta_pkg::SHAPE_LOW_W-1:0] lo,
		output logic [tta_pkg::SHAPE_HIGH_W-1:0] hi, output int total);
		int order [AXES];
		int i, j, t, d, lim;
		n = tta_pkg::AXIS_COUNT_W'($urandom_range(1, AXES));
		perm = tta_pkg::PERM_W'($urandom);
		lo = {$urandom, $urandom};
		hi = tta_pkg::SHAPE_HIGH_W'({$urandom, $urandom});
		for (i = 0; i < AXES; i++)
			order[i] = i;
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		total = 1;
		for (i = 0; i < n; i++) begin
			perm[3*i +: 3] = 3'(order[i]);
			lim = cap / total;
			if (n > 1 && lim > 6)
				lim = 6;
			d = $urandom_range(1, lim);
			total *= d;
			if (i < 4)
				lo[16*i +: 16] = 16'(d);
			else
				hi[16*(i-4) +: 16] = 16'(d);
		end
	endtask

	// reset leaves the walk finished; default registers give one element
	task automatic test_reset_state();
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		wait_drained();
	endtask

	// 2x3 swapped to 3x2, walked to the end and one word past it
	task automatic test_small_transpose();
		configure(3'd2, {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0, 3'd1},
			{16'd1, 16'd1, 16'd3, 16'd2}, {16'd1, 16'd1, 16'd1});
		send_request(1'b1);
		repeat (6) send_request(1'b0);
		wait_drained();
	endtask

	// element total exactly at the index span, and full-size axes
	task automatic test_index_range();
		configure(3'd4, {3'd6, 3'd5, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3},
			{16'd256, 16'd256, 16'd256, 16'd256}, {16'd1, 16'd1, 16'd1});
		send_request(1'b1);
		send_request(1'b0);
		wait_drained();
		configure(3'd2, {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0, 3'd1},
			{16'd0, 16'd0, 16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_request(1'b1);
		send_request(1'b0);
		wait_drained();
	endtask

	// total overflow, zero axes, out-of-range and repeated fields, zero size
	task automatic test_bad_config();
		configure(3'd5, {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
			{16'd256, 16'd256, 16'd256, 16'd256}, {16'd1, 16'd1, 16'd2});
		send_request(1'b1);
		send_request(1'b0);
		wait_drained();
		write_one(tta_pkg::REG_AXIS_COUNT, 64'd0);
		send_request(1'b1);
		wait_drained();
		configure(3'd3, {3'd6, 3'd5, 3'd4, 3'd3, 3'd0, 3'd1, 3'd1},
			{16'd1, 16'd2, 16'd2, 16'd2}, {16'd1, 16'd1, 16'd1});
		send_request(1'b1);
		wait_drained();
		configure(3'd2, {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd2, 3'd0},
			{16'd1, 16'd1, 16'd2, 16'd2}, {16'd1, 16'd1, 16'd1});
		send_request(1'b1);
		wait_drained();
		configure(3'd3, {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
			{16'd1, 16'd2, 16'd0, 16'd4}, {16'd1, 16'd1, 16'd1});
		send_request(1'b1);
		wait_drained();
	endtask

	// shrink an axis mid-walk, then point an axis at no real input axis
	task automatic test_reconfig_mid_walk();
		configure(3'd2, {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
			{16'd1, 16'd1, 16'd3, 16'd3}, {16'd1, 16'd1, 16'd1});
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
		wait_drained();
		write_one(tta_pkg::REG_SHAPE_LOW, {16'd1, 16'd1, 16'd2, 16'd3});
		send_request(1'b0);
		wait_drained();
		write_one(tta_pkg::REG_PERMUTATION,
			64'({3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd7, 3'd0}));
		send_request(1'b0);
		send_request(1'b0);
		wait_drained();
	endtask

	// mostly full walks; some rewrites mid-walk, bad configurations and noise
	task automatic test_random_mix(input int unsigned target);
		logic [tta_pkg::AXIS_COUNT_W-1:0] n;
		logic [tta_pkg::PERM_W-1:0]       perm;
		logic [tta_pkg::SHAPE_LOW_W-1:0]  lo;
		logic [tta_pkg::SHAPE_HIGH_W-1:0] hi;
		logic [tta_pkg::CFG_DATA_W-1:0]   data;
		int total, k, i, j, pick;
		while (items_sent < target) begin
			pick = $urandom_range(99);
			wait_drained();
			if (pick < 65) begin
				pick_walk_shape(48, n, perm, lo, hi, total);
				configure(n, perm, lo, hi);
				send_request(1'b1);
				// now and then restart partway and walk again from zero
				k = ($urandom_range(9) == 0) ? $urandom_range(1, total) : 0;
				for (i = 1; i < total + k; i++)
					send_request(k != 0 && i == k);
				repeat ($urandom_range(0, 2)) send_request(1'b0);
				walks_done++;
			end else if (pick < 80) begin
				pick_walk_shape(24, n, perm, lo, hi, total);
				configure(n, perm, lo, hi);
				send_request(1'b1);
				repeat ($urandom_range(0, total - 1)) send_request(1'b0);
				wait_drained();
				j = $urandom_range(0, 3);
				data = {$urandom, $urandom};
				if ($urandom_range(1) == 0) begin
					for (i = 0; i < 4; i++)
						data[16*i +: 16] = 16'($urandom_range(0, 4));
				end
				case (j)
					0: write_one(tta_pkg::REG_AXIS_COUNT, 64'($urandom_range(0, 7)));
					1: write_one(tta_pkg::REG_PERMUTATION, data);
					2: write_one(tta_pkg::REG_SHAPE_LOW, data);
					default: write_one(tta_pkg::REG_SHAPE_HIGH, data);
				endcase
				repeat ($urandom_range(4, 24)) send_request(1'b0);
				rewrites_done++;
			end else if (pick < 90) begin
				pick_walk_shape(48, n, perm, lo, hi, total);
				j = $urandom_range(0, 4);
				case (j)
					0: begin
						if (n > 1)
							perm[3*(n-1) +: 3] = perm[2:0];
						else
							perm[2:0] = 3'($urandom_range(1, 7));
					end
					1: begin
						i = $urandom_range(0, n - 1);
						perm[3*i +: 3] = 3'($urandom_range(n, 7));
					end
					2: begin
						i = $urandom_range(0, n - 1);
						if (i < 4)
							lo[16*i +: 16] = '0;
						else
							hi[16*(i-4) +: 16] = '0;
					end
					3: n = '0;
					default: begin
						n = tta_pkg::AXIS_COUNT_W'($urandom);
						perm = tta_pkg::PERM_W'($urandom);
						lo = {$urandom, $urandom};
						hi = tta_pkg::SHAPE_HIGH_W'({$urandom, $urandom});
					end
				endcase
				configure(n, perm, lo, hi);
				send_request(1'b1);
				repeat ($urandom_range(0, 2)) send_request(1'b0);
				bad_cfg_cases++;
			end else begin
				repeat ($urandom_range(2, 6)) send_request($urandom_range(3) == 0);
			end
		end
	endtask

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.restart <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= tta_pkg::REG_AXIS_COUNT;
		cfg_data <= '0;
		arst_n <= 1'b0;
		m_axis_count = tta_pkg::RST_AXIS_COUNT;
		m_perm = tta_pkg::RST_PERM;
		m_shape_low = tta_pkg::RST_SHAPE_LOW;
		m_shape_high = tta_pkg::RST_SHAPE_HIGH;
		for (int i = 0; i < 8; i++) begin
			odo[i] = '0;
			stride[i] = '0;
		end
		src_acc = '0;
		dst_acc = '0;
		walking = 1'b0;
		bad_cfg = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_small_transpose();
		test_index_range();
		test_bad_config();
		test_reconfig_mid_walk();

		// idling phases: none, sender, receiver, both
		test_random_mix(items_sent + 280);
		send_idle_pct = 58;
		test_random_mix(items_sent + 280);
		send_idle_pct = 0;
		recv_stall_pct = 58;
		test_random_mix(items_sent + 280);
		send_idle_pct = 16;
		recv_stall_pct = 16;
		test_random_mix(items_sent + 280);

		wait_drained();
		repeat (24) @(posedge clk);
		mismatch_count += pending_addr_q.size();
		$display("summary: %0d request words sent, %0d response words checked",
			items_sent, words_checked);
		$display("summary: %0d full walks, %0d bad configurations, %0d mid-walk rewrites",
			walks_done, bad_cfg_cases, rewrites_done);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d words still expected", $time, pending_addr_q.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
